// ===== src/shrp_pkg.sv =====
package shrp_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 4096;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int LW_W       = 12;
   localparam int FH_W       = 13;
   localparam int CHAN_W     = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 13;

   localparam logic [LW_W-1:0] LINE_WIDTH_RESET   = LW_W'(640);
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = FH_W'(480);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LINE_WIDTH   = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_type;

   typedef struct packed {
      rgb_type upper;
      rgb_type middle;
   } line_pair_type;

   typedef struct packed {
      logic             en;
      logic [COL_W-1:0] addr;
   } lb_rd_type;

   typedef struct packed {
      logic             en;
      logic [COL_W-1:0] addr;
      line_pair_type    data;
   } lb_wr_type;

   // 5*c - n - s - w - e, clamped to 0..255
   function automatic logic [CHAN_W-1:0] sharpen_chan(
      input logic [CHAN_W-1:0] c,
      input logic [CHAN_W-1:0] n,
      input logic [CHAN_W-1:0] s,
      input logic [CHAN_W-1:0] w,
      input logic [CHAN_W-1:0] e
   );
      logic        [10:0] pos;
      logic        [9:0]  neg;
      logic signed [11:0] sum;
      logic [CHAN_W-1:0]  res;
      pos = {1'b0, c, 2'b00} + {3'b000, c};
      neg = {2'b00, n} + {2'b00, s} + {2'b00, w} + {2'b00, e};
      sum = $signed({1'b0, pos}) - $signed({2'b00, neg});
      if (sum < 12'sd0) begin
         res = '0;
      end else if (sum > 12'sd255) begin
         res = '1;
      end else begin
         res = sum[CHAN_W-1:0];
      end
      return res;
   endfunction

endpackage

// ===== src/shrp_if.sv =====
interface shrp_req_if;
   import shrp_pkg::*;
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] in_red;
   logic [CHAN_W-1:0] in_green;
   logic [CHAN_W-1:0] in_blue;
   logic              frame_start;
   modport source (output valid, output in_red, output in_green, output in_blue,
                   output frame_start, input ready);
   modport sink   (input valid, input in_red, input in_green, input in_blue,
                   input frame_start, output ready);
endinterface

interface shrp_rsp_if;
   import shrp_pkg::*;
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] out_red;
   logic [CHAN_W-1:0] out_green;
   logic [CHAN_W-1:0] out_blue;
   logic              row_end;
   logic              frame_end;
   modport source (output valid, output out_red, output out_green, output out_blue,
                   output row_end, output frame_end, input ready);
   modport sink   (input valid, input out_red, input out_green, input out_blue,
                   input row_end, input frame_end, output ready);
endinterface

interface shrp_csr_if;
   import shrp_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/shrp_line_buf.sv =====
module shrp_line_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  shrp_pkg::lb_rd_type   rd,
   input  shrp_pkg::lb_wr_type   wr,
   output shrp_pkg::line_pair_type rd_data,
   output logic                  busy
);
   import shrp_pkg::*;

   line_pair_type    line_mem_ff [MAX_WIDTH];
   line_pair_type    rd_q_ff;
   line_pair_type    byp_data_ff;
   logic             byp_hit_ff;
   logic             clr_busy_ff;
   logic [COL_W-1:0] clr_addr_ff;

   logic             mem_we;
   logic [COL_W-1:0] mem_waddr;
   line_pair_type    mem_wdata;

   always_comb begin
      if (clr_busy_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = wr.en;
         mem_waddr = wr.addr;
         mem_wdata = wr.data;
      end
   end

   // zeroing sweep after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + COL_W'(1);
         if (clr_addr_ff == COL_W'(MAX_WIDTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (rd.en) begin
         rd_q_ff     <= line_mem_ff[rd.addr];
         byp_data_ff <= wr.data;
      end
   end

   // same-edge write to the read address: forward the new data
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_hit_ff <= 1'b0;
      end else if (rd.en) begin
         byp_hit_ff <= wr.en && (wr.addr == rd.addr);
      end
   end

   assign rd_data = byp_hit_ff ? byp_data_ff : rd_q_ff;
   assign busy    = clr_busy_ff;

endmodule

// ===== src/sharpen_3x3_rgb_filter_top.sv =====
// 3x3 sharpen filter (center 5, edge neighbors -1) on a raster RGB pixel
// stream, one pixel per clock sustained while the result side takes results.
// A result appears for each input pixel at row 2 or later and column 2 or
// later, and is the filtered pixel one row up and one column left, so a
// frame yields (width-2) x (height-2) results, clamped to 0..255, with
// row_end / frame_end on the last result of a row / frame. The line-buffer
// read is registered at the accepting edge, the kernel runs on it, and its
// result enters the result register when that stage advances. After reset
// the line buffer is zeroed in a sweep over all 2048 entries, during which
// req_bus.ready stays low; register writes are taken at any time.
// frame_start restarts the column and row counters; counters also wrap
// after the last pixel of a frame. Width and height are clamped to
// 3..2048 and 3..4096 and should be written only while the block is idle.
module sharpen_3x3_rgb_filter_top (
   input logic          clock,
   input logic          reset,
   shrp_req_if.sink     req_bus,
   shrp_rsp_if.source   rsp_bus,
   shrp_csr_if.sink     csr_bus
);
   import shrp_pkg::*;

   logic [LW_W-1:0]  line_width_ff;
   logic [FH_W-1:0]  frame_height_ff;
   logic [COL_W-1:0] column_count_ff;
   logic [ROW_W-1:0] row_count_ff;

   logic             s1_valid_ff;
   rgb_type          s1_px_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic             s1_emit_ff;
   logic             s1_row_end_ff;
   logic             s1_frame_end_ff;

   rgb_type          win_top0_ff;
   rgb_type          win_mid0_ff;
   rgb_type          win_mid1_ff;
   rgb_type          win_bot0_ff;

   logic             rsp_valid_ff;
   rgb_type          rsp_px_ff;
   logic             rsp_row_end_ff;
   logic             rsp_frame_end_ff;

   logic [COL_W-1:0] col_lim;
   logic [ROW_W-1:0] row_lim;
   logic [COL_W-1:0] cur_col;
   logic [ROW_W-1:0] cur_row;
   logic [COL_W-1:0] col;
   logic [ROW_W-1:0] row;
   logic             last_col;
   logic             last_row;
   logic             req_fire;
   logic             s1_adv;
   logic             lb_busy;
   lb_rd_type        lb_rd;
   lb_wr_type        lb_wr;
   line_pair_type    lb_q;
   rgb_type          req_px;
   rgb_type          sharp_px;

   // configuration registers
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= LINE_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_index_type'(csr_bus.index))
            CSR_LINE_WIDTH:   line_width_ff   <= csr_bus.data[LW_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_bus.data[FH_W-1:0];
         endcase
      end
   end

   // effective last column / row
   always_comb begin
      if (line_width_ff < LW_W'(3)) begin
         col_lim = COL_W'(2);
      end else if (line_width_ff > LW_W'(MAX_WIDTH)) begin
         col_lim = COL_W'(MAX_WIDTH - 1);
      end else begin
         col_lim = COL_W'(line_width_ff - LW_W'(1));
      end
      if (frame_height_ff < FH_W'(3)) begin
         row_lim = ROW_W'(2);
      end else if (frame_height_ff > FH_W'(MAX_HEIGHT)) begin
         row_lim = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         row_lim = ROW_W'(frame_height_ff - FH_W'(1));
      end
   end

   // stage A: position of the incoming pixel
   always_comb begin
      cur_col  = req_bus.frame_start ? '0 : column_count_ff;
      cur_row  = req_bus.frame_start ? '0 : row_count_ff;
      col      = (cur_col >= col_lim) ? col_lim : cur_col;
      row      = (cur_row >= row_lim) ? row_lim : cur_row;
      last_col = (col == col_lim);
      last_row = (row == row_lim);
   end

   assign s1_adv        = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !lb_busy && (!s1_valid_ff || s1_adv);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign req_px        = '{red: req_bus.in_red, green: req_bus.in_green,
                            blue: req_bus.in_blue};

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
      end else if (req_fire) begin
         if (last_col) begin
            column_count_ff <= '0;
            row_count_ff    <= last_row ? '0 : row + ROW_W'(1);
         end else begin
            column_count_ff <= col + COL_W'(1);
            row_count_ff    <= row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_px_ff        <= req_px;
         s1_col_ff       <= col;
         s1_emit_ff      <= (row >= ROW_W'(2)) && (col >= COL_W'(2));
         s1_row_end_ff   <= last_col;
         s1_frame_end_ff <= last_col && last_row;
      end
   end

   // line stores: upper and middle rows share one address
   assign lb_rd = '{en: req_fire, addr: col};
   assign lb_wr = '{en: s1_adv, addr: s1_col_ff,
                    data: '{upper: lb_q.middle, middle: s1_px_ff}};

   shrp_line_buf u_line_buf (
      .clock   (clock),
      .reset   (reset),
      .rd      (lb_rd),
      .wr      (lb_wr),
      .rd_data (lb_q),
      .busy    (lb_busy)
   );

   // stage B: kernel
   always_comb begin
      sharp_px.red   = sharpen_chan(win_mid0_ff.red, win_top0_ff.red, win_bot0_ff.red,
                                    win_mid1_ff.red, lb_q.middle.red);
      sharp_px.green = sharpen_chan(win_mid0_ff.green, win_top0_ff.green,
                                    win_bot0_ff.green, win_mid1_ff.green,
                                    lb_q.middle.green);
      sharp_px.blue  = sharpen_chan(win_mid0_ff.blue, win_top0_ff.blue, win_bot0_ff.blue,
                                    win_mid1_ff.blue, lb_q.middle.blue);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_top0_ff <= '0;
         win_mid0_ff <= '0;
         win_mid1_ff <= '0;
         win_bot0_ff <= '0;
      end else if (s1_adv) begin
         win_mid1_ff <= win_mid0_ff;
         win_top0_ff <= lb_q.upper;
         win_mid0_ff <= lb_q.middle;
         win_bot0_ff <= s1_px_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= s1_emit_ff;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_px_ff        <= sharp_px;
         rsp_row_end_ff   <= s1_row_end_ff;
         rsp_frame_end_ff <= s1_frame_end_ff;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.out_red   = rsp_px_ff.red;
   assign rsp_bus.out_green = rsp_px_ff.green;
   assign rsp_bus.out_blue  = rsp_px_ff.blue;
   assign rsp_bus.row_end   = rsp_row_end_ff;
   assign rsp_bus.frame_end = rsp_frame_end_ff;

endmodule

// ===== tb/sv/sharpen_checker.sv =====
module sharpen_checker
   import shrp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   shrp_req_if  req_bus,
   shrp_rsp_if  rsp_bus,
   shrp_csr_if  csr_bus,
   output int   mismatches,
   output int   waiting,
   output int   results_seen,
   output int   frame_ends
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      rgb_type pixel;
      logic    row_end;
      logic    frame_end;
   } filtered_type;

   logic [LW_W-1:0] line_width;
   logic [FH_W-1:0] frame_height;
   rgb_type         upper_row  [MAX_WIDTH];
   rgb_type         middle_row [MAX_WIDTH];
   rgb_type         win_near   [3];   // column - 1: top, middle, bottom
   rgb_type         win_far    [3];   // column - 2
   int              col_pos;
   int              row_pos;
   filtered_type    filtered_q [$];

   function automatic logic [CHAN_W-1:0] sharpen_value(int center, int north, int south,
                                                       int west, int east);
      int sum;
      sum = 5 * center - north - south - west - east;
      if (sum < 0) begin
         sum = 0;
      end else if (sum > 255) begin
         sum = 255;
      end
      return sum[CHAN_W-1:0];
   endfunction

   task automatic filter_pixel(input rgb_type px, input logic restart);
      int           w_eff;
      int           h_eff;
      int           col;
      int           row;
      rgb_type      upper_px;
      rgb_type      middle_px;
      filtered_type res;
      w_eff = int'(line_width);
      h_eff = int'(frame_height);
      if (w_eff < 3) w_eff = 3;
      if (w_eff > MAX_WIDTH) w_eff = MAX_WIDTH;
      if (h_eff < 3) h_eff = 3;
      if (h_eff > MAX_HEIGHT) h_eff = MAX_HEIGHT;
      if (restart) begin
         col_pos = 0;
         row_pos = 0;
      end
      col = (col_pos < w_eff - 1) ? col_pos : w_eff - 1;
      row = (row_pos < h_eff - 1) ? row_pos : h_eff - 1;
      upper_px  = upper_row[col];
      middle_px = middle_row[col];
      if (row >= 2 && col >= 2) begin
         res.pixel.red   = sharpen_value(win_near[1].red, win_near[0].red, win_near[2].red,
                                         win_far[1].red, middle_px.red);
         res.pixel.green = sharpen_value(win_near[1].green, win_near[0].green,
                                         win_near[2].green, win_far[1].green, middle_px.green);
         res.pixel.blue  = sharpen_value(win_near[1].blue, win_near[0].blue, win_near[2].blue,
                                         win_far[1].blue, middle_px.blue);
         res.row_end     = (col == w_eff - 1);
         res.frame_end   = (col == w_eff - 1) && (row == h_eff - 1);
         filtered_q.push_back(res);
      end
      upper_row[col]  = middle_px;
      middle_row[col] = px;
      win_far         = win_near;
      win_near[0]     = upper_px;
      win_near[1]     = middle_px;
      win_near[2]     = px;
      if (col == w_eff - 1) begin
         col_pos = 0;
         row_pos = (row == h_eff - 1) ? 0 : row + 1;
      end else begin
         col_pos = col + 1;
         row_pos = row;
      end
   endtask

   task automatic check_result();
      filtered_type want;
      filtered_type got;
      got.pixel     = {rsp_bus.out_red, rsp_bus.out_green, rsp_bus.out_blue};
      got.row_end   = rsp_bus.row_end;
      got.frame_end = rsp_bus.frame_end;
      results_seen++;
      if (got.frame_end === 1'b1) frame_ends++;
      if (filtered_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t: unexpected result transaction rgb %02h %02h %02h row_end %b frame_end %b",
                     $realtime, got.pixel.red, got.pixel.green, got.pixel.blue,
                     got.row_end, got.frame_end);
         end
      end else begin
         want = filtered_q.pop_front();
         if (got.pixel.red !== want.pixel.red || got.pixel.green !== want.pixel.green ||
             got.pixel.blue !== want.pixel.blue || got.row_end !== want.row_end ||
             got.frame_end !== want.frame_end) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: result %0d expected rgb %02h %02h %02h row_end %b frame_end %b",
                        $realtime, results_seen, want.pixel.red, want.pixel.green,
                        want.pixel.blue, want.row_end, want.frame_end);
               $display("%0t: result %0d actual   rgb %02h %02h %02h row_end %b frame_end %b",
                        $realtime, results_seen, got.pixel.red, got.pixel.green,
                        got.pixel.blue, got.row_end, got.frame_end);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         line_width   = LINE_WIDTH_RESET;
         frame_height = FRAME_HEIGHT_RESET;
         for (int i = 0; i < MAX_WIDTH; i++) begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
         end
         for (int i = 0; i < 3; i++) begin
            win_near[i] = '0;
            win_far[i]  = '0;
         end
         col_pos      = 0;
         row_pos      = 0;
         mismatches   = 0;
         results_seen = 0;
         frame_ends   = 0;
         filtered_q.delete();
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_index_type'(csr_bus.index))
               CSR_LINE_WIDTH: begin
                  line_width = csr_bus.data[LW_W-1:0];
               end
               CSR_FRAME_HEIGHT: begin
                  frame_height = csr_bus.data[FH_W-1:0];
               end
               default: begin
               end
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            filter_pixel({req_bus.in_red, req_bus.in_green, req_bus.in_blue},
                         req_bus.frame_start);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            check_result();
         end
      end
      waiting = filtered_q.size();
   end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top import shrp_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT    = 20000;
   localparam int RANDOM_PIXELS = 1160;

   logic clock = 1'b0;
   logic reset = 1'b1;

   shrp_req_if req_bus ();
   shrp_rsp_if rsp_bus ();
   shrp_csr_if csr_bus ();

   int mismatches;
   int waiting;
   int results_seen;
   int frame_ends;
   int pixels_sent = 0;
   int csr_writes  = 0;
   int idle_cycles = 0;
   int stall_left  = 0;
   bit req_gaps    = 1'b0;
   bit rsp_gaps    = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sharpen_3x3_rgb_filter_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   sharpen_checker filter_check (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus),
      .csr_bus      (csr_bus),
      .mismatches   (mismatches),
      .waiting      (waiting),
      .results_seen (results_seen),
      .frame_ends   (frame_ends)
   );

   // result side backpressure: a stall length is drawn after every result transaction while rsp_gaps is set
   always @(posedge clock) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
         stall_left <= rsp_gaps ? int'($urandom_range(11, 0)) : 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end
   end

   always @(negedge clock) begin
      rsp_bus.ready <= (stall_left == 0);
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[sharpen_3x3_rgb_filter_top] ERROR");
         $finish;
      end
   end

   function automatic logic [CHAN_W-1:0] random_level();
      case ($urandom_range(7, 0))
         0: return '0;
         1: return '1;
         default: return CHAN_W'($urandom_range(255, 0));
      endcase
   endfunction

   function automatic rgb_type random_pixel();
      rgb_type px;
      px.red   = random_level();
      px.green = random_level();
      px.blue  = random_level();
      return px;
   endfunction

   task automatic send_pixel(input rgb_type px, input logic restart);
      int gap;
      gap = req_gaps ? int'($urandom_range(11, 0)) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.in_red      <= px.red;
      req_bus.in_green    <= px.green;
      req_bus.in_blue     <= px.blue;
      req_bus.frame_start <= restart;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      pixels_sent++;
   endtask

   task automatic send_run(input int count, input bit restart_first);
      for (int i = 0; i < count; i++) begin
         send_pixel(random_pixel(), restart_first && i == 0);
      end
   endtask

   task automatic send_3x3(input rgb_type center, input rgb_type around, input bit restart);
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            send_pixel((r == 1 && c == 1) ? center : around, restart && r == 0 && c == 0);
         end
      end
   endtask

   // sender holds off until every expected result is out, plus pipeline latency
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (waiting != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_writes++;
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] width,
                            input logic [CSR_DATA_W-1:0] height);
      drain();
      write_csr(CSR_LINE_WIDTH, width);
      write_csr(CSR_FRAME_HEIGHT, height);
      csr_bus.valid <= 1'b0;
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] lw;
      logic [CSR_DATA_W-1:0] fh;
      int                    w_eff;
      int                    h_eff;
      int                    frame_len;
      int                    run;
      int                    base;
      bit                    first;
      bit                    hold_mid;
      logic                  restart;

      req_bus.valid       = 1'b0;
      req_bus.in_red      = '0;
      req_bus.in_green    = '0;
      req_bus.in_blue     = '0;
      req_bus.frame_start = 1'b0;
      rsp_bus.ready       = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = CSR_LINE_WIDTH;
      csr_bus.data        = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // smallest frame: width and height below range clamp to 3
      configure(13'd2, 13'd0);
      send_3x3('{red: 8'hFF, green: 8'h00, blue: 8'd60},
               '{red: 8'h00, green: 8'hFF, blue: 8'd20}, 1'b1);
      // next frame starts by counter wrap alone
      send_3x3('{red: 8'h00, green: 8'hFF, blue: 8'd128},
               '{red: 8'hFF, green: 8'h00, blue: 8'd127}, 1'b0);
      send_pixel(random_pixel(), 1'b1);
      send_pixel(random_pixel(), 1'b0);
      send_pixel(random_pixel(), 1'b0);
      send_pixel(random_pixel(), 1'b1);

      // width, then height, above range: counters must not wrap early
      rsp_gaps = 1'b1;
      configure(13'h1FFF, 13'd3);
      send_run(96, 1'b1);
      rsp_gaps = 1'b0;
      configure(13'd3, 13'h1FFF);
      send_run(3 * 40, 1'b1);

      base  = pixels_sent;
      first = 1'b1;
      while (pixels_sent < base + RANDOM_PIXELS) begin
         req_gaps = ($urandom_range(2, 0) != 0);
         rsp_gaps = ($urandom_range(2, 0) != 0);
         case ($urandom_range(19, 0))
            0:       lw = CSR_DATA_W'($urandom_range(2, 0));
            1:       lw = CSR_DATA_W'(MAX_WIDTH);
            2:       lw = CSR_DATA_W'($urandom_range(4095, 0));
            3, 4:    lw = CSR_DATA_W'($urandom_range(80, 25));
            default: lw = CSR_DATA_W'($urandom_range(24, 3));
         endcase
         case ($urandom_range(19, 0))
            0:       fh = CSR_DATA_W'($urandom_range(2, 0));
            1:       fh = CSR_DATA_W'(MAX_HEIGHT);
            2, 3:    fh = CSR_DATA_W'($urandom_range(8191, 0));
            default: fh = CSR_DATA_W'($urandom_range(12, 3));
         endcase
         lw[CSR_DATA_W-1] = $urandom_range(1, 0);
         configure(lw, fh);
         w_eff = int'(lw[LW_W-1:0]);
         h_eff = int'(fh);
         if (w_eff < 3) w_eff = 3;
         if (w_eff > MAX_WIDTH) w_eff = MAX_WIDTH;
         if (h_eff < 3) h_eff = 3;
         if (h_eff > MAX_HEIGHT) h_eff = MAX_HEIGHT;
         frame_len = (w_eff * h_eff > 400) ? 400 : w_eff * h_eff;
         repeat ($urandom_range(3, 1)) begin
            run = frame_len;
            if ($urandom_range(9, 0) == 0) run = $urandom_range(frame_len, 1);
            hold_mid = first || ($urandom_range(5, 0) == 0);
            first    = 1'b0;
            for (int i = 0; i < run && pixels_sent < base + RANDOM_PIXELS; i++) begin
               if (hold_mid && i == run / 2) drain();
               if (i == 0) begin
                  restart = ($urandom_range(7, 0) != 0);
               end else begin
                  restart = ($urandom_range(63, 0) == 0);
               end
               send_pixel(random_pixel(), restart);
            end
         end
      end

      drain();
      repeat (6) @(negedge clock);
      $display("covered %0d pixel transactions and %0d register writes, sizes below and above the clamp",
               pixels_sent, csr_writes);
      $display("checked %0d filtered pixels including %0d frame ends, %0d mismatches",
               results_seen, frame_ends, mismatches);
      if (mismatches == 0 && waiting == 0) begin
         $display("[sharpen_3x3_rgb_filter_top] OK");
      end else begin
         $display("[sharpen_3x3_rgb_filter_top] ERROR");
      end
      $finish;
   end

endmodule
